FILE: sv/msbbp_pkg.sv
// msbbp_pkg: shared constants, register indexes and the command type of the
// msb-first bit packer. No dependencies.
package msbbp_pkg;

  localparam int unsigned DEF_MAX_VALUES = 65535;
  localparam int unsigned DEF_MAX_WIDTH  = 32;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned ADDR_W   = 18;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned WIDTH_W  = 6;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned POS_W    = 22;
  localparam int unsigned BPOS_W   = POS_W - 3;
  localparam int unsigned WIN_W    = 40;
  localparam int unsigned NB_W     = 3;

  localparam logic [WIDTH_W-1:0] RESET_WIDTH = 6'd8;

  // power of two
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_VALUE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_WIDTH = 1'b1;

  typedef struct packed {
    logic              reject;
    logic [ADDR_W-1:0] addr;
    logic [WIN_W-1:0]  word;
    logic [NB_W-1:0]   nbytes;
  } cmd_t;

endpackage

FILE: sv/msbbp_if.sv
// msbbp_item_if and msbbp_result_if: valid/ready channels of the packer.
// Depends on msbbp_pkg.
interface msbbp_item_if;
  logic                          valid;
  logic                          ready;
  logic [msbbp_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface msbbp_result_if;
  logic                         valid;
  logic                         ready;
  logic                         accepted;
  logic [msbbp_pkg::ADDR_W-1:0] byte_addr;
  logic [msbbp_pkg::BYTE_W-1:0] byte_data;
  logic                         last;

  modport source (output valid, output accepted, output byte_addr, output byte_data,
                  output last, input ready);
  modport sink   (input valid, input accepted, input byte_addr, input byte_data,
                  input last, output ready);
endinterface

FILE: sv/msbbp_front.sv
// msbbp_front: config registers, bit position state and per-value classification.
// Turns each accepted value into one command for the back end. Depends on msbbp_pkg.
module msbbp_front #(
  parameter int unsigned MAX_VALUES = msbbp_pkg::DEF_MAX_VALUES,
  parameter int unsigned MAX_WIDTH  = msbbp_pkg::DEF_MAX_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [msbbp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [msbbp_pkg::CFG_W-1:0]       cfg_data,
  msbbp_item_if.sink                        item,
  output logic                              push_valid,
  input  logic                              push_ready,
  output msbbp_pkg::cmd_t                   push_cmd
);

  localparam int unsigned CNT_W  = $clog2(MAX_VALUES + 1);
  localparam int unsigned PROD_W = CNT_W + msbbp_pkg::WIDTH_W;
  localparam int unsigned BC_W   = PROD_W - 2;
  localparam int unsigned CMP_W  = (BC_W > msbbp_pkg::BPOS_W) ? BC_W : msbbp_pkg::BPOS_W;
  localparam int unsigned CW_X   = (CNT_W > msbbp_pkg::COUNT_W) ? CNT_W : msbbp_pkg::COUNT_W;
  localparam logic [CW_X-1:0] MAX_VALUES_X = CW_X'(MAX_VALUES);
  localparam logic [msbbp_pkg::WIDTH_W-1:0] MAX_WIDTH_C = msbbp_pkg::WIDTH_W'(MAX_WIDTH);

  logic [msbbp_pkg::COUNT_W-1:0] value_count;
  logic [msbbp_pkg::WIDTH_W-1:0] value_width;
  logic [msbbp_pkg::POS_W-1:0]   next_bit_pos, next_bit_pos_next;
  logic [msbbp_pkg::BYTE_W-1:0]  partial_byte, partial_byte_next;
  logic [BC_W-1:0]               byte_count;
  logic                          cfg_pend;

  logic [CW_X-1:0]               count_x;
  logic [CNT_W-1:0]              count_eff;
  logic [PROD_W:0]               prod_rnd;
  logic                          disabled;
  logic [CMP_W-1:0]              b_x, bc_x, avail;
  logic                          full;
  logic [2:0]                    off;
  logic [msbbp_pkg::VALUE_W-1:0] v_masked;
  logic [5:0]                    sh;
  logic [msbbp_pkg::WIN_W-1:0]   word, word_tail;
  logic [5:0]                    span;
  logic [msbbp_pkg::NB_W-1:0]    nbytes, n_emit;
  logic                          reject;
  logic                          take;

  // byte_count is registered; input is held off in the cycle after a write
  always_comb begin
    count_x   = CW_X'(value_count);
    count_eff = (count_x > MAX_VALUES_X) ? CNT_W'(MAX_VALUES) : CNT_W'(count_x);
    prod_rnd  = (PROD_W+1)'(count_eff) * (PROD_W+1)'(value_width) + (PROD_W+1)'(7);
  end

  always_comb begin
    disabled = (value_count == '0) || (value_width == '0) || (value_width > MAX_WIDTH_C);
    b_x      = CMP_W'(next_bit_pos[msbbp_pkg::POS_W-1:3]);
    bc_x     = CMP_W'(byte_count);
    full     = (b_x >= bc_x);
    avail    = bc_x - b_x;
    off      = next_bit_pos[2:0];
    v_masked = item.value & ~({msbbp_pkg::VALUE_W{1'b1}} << value_width);
    sh       = 6'd40 - 6'(off) - value_width;
    word     = {partial_byte, 32'd0}
             | ({{(msbbp_pkg::WIN_W-msbbp_pkg::VALUE_W){1'b0}}, v_masked} << sh);
    span     = 6'(off) + value_width + 6'd7;
    nbytes   = span[5:3];
    n_emit   = (avail < CMP_W'(nbytes)) ? avail[msbbp_pkg::NB_W-1:0] : nbytes;
    reject   = disabled || full;
    word_tail = word << {nbytes - 3'd1, 3'b000};
  end

  always_comb begin
    push_valid     = item.valid && !cfg_pend;
    item.ready     = push_ready && !cfg_pend;
    push_cmd.reject = reject;
    push_cmd.addr   = reject ? '0 : next_bit_pos[msbbp_pkg::ADDR_W+2:3];
    push_cmd.word   = reject ? '0 : word;
    push_cmd.nbytes = reject ? 3'd1 : n_emit;
    take           = item.valid && item.ready;
    next_bit_pos_next = next_bit_pos + msbbp_pkg::POS_W'(value_width);
    partial_byte_next = (next_bit_pos_next[2:0] != 3'd0)
                      ? word_tail[msbbp_pkg::WIN_W-1 -: msbbp_pkg::BYTE_W] : '0;
  end

  always_ff @(posedge clk) begin
    byte_count <= prod_rnd[PROD_W:3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value_count  <= '0;
      value_width  <= msbbp_pkg::RESET_WIDTH;
      next_bit_pos <= '0;
      partial_byte <= '0;
      cfg_pend     <= 1'b1;
    end else begin
      cfg_pend <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          msbbp_pkg::REG_VALUE_COUNT: value_count <= cfg_data[msbbp_pkg::COUNT_W-1:0];
          msbbp_pkg::REG_VALUE_WIDTH: value_width <= cfg_data[msbbp_pkg::WIDTH_W-1:0];
          default: ;
        endcase
        next_bit_pos <= '0;
        partial_byte <= '0;
      end else if (take && !reject) begin
        next_bit_pos <= next_bit_pos_next;
        partial_byte <= partial_byte_next;
      end
    end
  end

endmodule

FILE: sv/msbbp_queue.sv
// msbbp_queue: small register queue of commands between front and back end.
// Depends on msbbp_pkg.
module msbbp_queue #(
  parameter int unsigned DEPTH = msbbp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  msbbp_pkg::cmd_t push_cmd,
  output logic            pop_valid,
  input  logic            pop_ready,
  output msbbp_pkg::cmd_t pop_cmd
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  msbbp_pkg::cmd_t   slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [PTR_W:0]    fill;
  logic              do_push, do_pop;

  always_comb begin
    push_ready = (fill != (PTR_W+1)'(DEPTH));
    pop_valid  = (fill != '0);
    pop_cmd    = slots[rd_ptr];
    do_push    = push_valid && push_ready;
    do_pop     = pop_valid && pop_ready;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      fill <= fill + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
  end

endmodule

FILE: sv/msbbp_back.sv
// msbbp_back: plays out one command as byte write beats, one beat per cycle while result is ready.
// Depends on msbbp_pkg and msbbp_result_if.
module msbbp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  msbbp_pkg::cmd_t pop_cmd,
  msbbp_result_if.source  result
);

  logic            cur_valid;
  msbbp_pkg::cmd_t cur;
  logic            beat_done, load;

  always_comb begin
    beat_done        = result.valid && result.ready;
    load             = !cur_valid || (beat_done && cur.nbytes == 3'd1);
    pop_ready        = load;
    result.valid     = cur_valid;
    result.accepted  = !cur.reject;
    result.byte_addr = cur.addr;
    result.byte_data = cur.word[msbbp_pkg::WIN_W-1 -: msbbp_pkg::BYTE_W];
    result.last      = (cur.nbytes == 3'd1);
  end

  always_ff @(posedge clk) begin
    if (load && pop_valid) begin
      cur <= pop_cmd;
    end else if (beat_done) begin
      cur.addr   <= cur.addr + msbbp_pkg::ADDR_W'(1);
      cur.word   <= cur.word << msbbp_pkg::BYTE_W;
      cur.nbytes <= cur.nbytes - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (load) begin
      cur_valid <= pop_valid;
    end
  end

endmodule

FILE: sv/msbbp_top.sv
// msb_first_bit_packer_top: top level of the msb-first bit packer.
// Depends on msbbp_pkg, msbbp_if, msbbp_front, msbbp_queue and msbbp_back.
//
// Packs values of value_width bits, msb first, into a byte buffer sized for
// value_count values and reports every byte a value touches as one result beat
// (byte index and full new byte contents, last set on the final beat of the
// value). A value is rejected with one beat (accepted low, address and data
// zero) when packing is disabled, the width is above MAX_WIDTH or the start
// byte lies past the buffer; bytes past the buffer end are dropped. Rate: the
// front end takes one value per cycle while the command queue has room, and
// the back end sends one byte beat per cycle; a value has 1 to 5 beats (5 for
// a 32-bit value that starts off a byte boundary), and the result port sets
// the sustained rate. A config write resets the bit position and holds off
// input for the cycle after it while the buffer size is recomputed.
module msb_first_bit_packer_top #(
  parameter int unsigned MAX_VALUES = msbbp_pkg::DEF_MAX_VALUES,
  parameter int unsigned MAX_WIDTH  = msbbp_pkg::DEF_MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [msbbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [msbbp_pkg::CFG_W-1:0]     cfg_data,
  msbbp_item_if.sink                      item,
  msbbp_result_if.source                  result
);

  // front to queue
  logic            push_valid, push_ready;
  msbbp_pkg::cmd_t push_cmd;
  // queue to back
  logic            pop_valid, pop_ready;
  msbbp_pkg::cmd_t pop_cmd;

  // classify values, keep position and partial byte
  msbbp_front #(
    .MAX_VALUES (MAX_VALUES),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // decouples the value side from the byte beat side
  msbbp_queue #(
    .DEPTH (msbbp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // registered byte beat output
  msbbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .result    (result)
  );

endmodule

FILE: tb/tb_msb_first_bit_packer_top.sv
// tb_msb_first_bit_packer_top: self-checking testbench of the msb-first bit packer.
// Depends on msbbp_pkg, msbbp_if and msb_first_bit_packer_top.
`timescale 1ns / 100ps

module tb_msb_first_bit_packer_top;

  // run limits
  localparam int unsigned CYCLE_LIMIT   = 100000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned RANDOM_ITEMS  = 45;
  localparam int unsigned HOLD_CYCLES   = 200;

  // one expected result beat
  typedef struct packed {
    logic                         accepted;
    logic [msbbp_pkg::ADDR_W-1:0] byte_addr;
    logic [msbbp_pkg::BYTE_W-1:0] byte_data;
    logic                         last;
  } byte_write_t;

  // receiver stall patterns
  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_SLOW} rx_mode_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_we;
  logic [msbbp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [msbbp_pkg::CFG_W-1:0]     cfg_data;

  msbbp_item_if   item_ch ();
  msbbp_result_if result_ch ();

  msb_first_bit_packer_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  // mirror of the packer: layout registers and packing position
  logic [msbbp_pkg::COUNT_W-1:0] cfg_count = '0;
  logic [msbbp_pkg::WIDTH_W-1:0] cfg_width = msbbp_pkg::RESET_WIDTH;
  logic [msbbp_pkg::POS_W-1:0]   pos_bits  = '0;
  logic [msbbp_pkg::BYTE_W-1:0]  held_byte = '0;

  // byte writes predicted but not yet seen on the result port
  byte_write_t writes_due[$];

  int unsigned errors      = 0;
  int unsigned cycle_count = 0;

  // sender pacing
  bit          sender_gaps = 1'b0;
  int unsigned burst_left  = 0;

  // receiver pacing; hold_req starts a long stall counted by the receiver
  rx_mode_t    rx_mode     = RX_OPEN;
  bit          hold_req    = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned rx_phase    = 0;

  // clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor: works out the byte writes caused by one accepted value
  // ---------------------------------------------------------------------------
  function automatic void push_reject();
    byte_write_t bw;
    bw = '{accepted: 1'b0, byte_addr: '0, byte_data: '0, last: 1'b1};
    writes_due.push_back(bw);
  endfunction

  function automatic void pack_value(input logic [msbbp_pkg::VALUE_W-1:0] v);
    int unsigned   count;
    int unsigned   w;
    int unsigned   buf_bytes;
    int unsigned   start;
    int unsigned   first_byte;
    int unsigned   off;
    int unsigned   nb;
    int unsigned   k;
    int unsigned   newpos;
    logic [31:0]   masked;
    logic [msbbp_pkg::WIN_W-1:0] window;
    byte_write_t   bw;

    count = cfg_count;
    // counts above the buffer limit are clamped
    if (count > msbbp_pkg::DEF_MAX_VALUES) count = msbbp_pkg::DEF_MAX_VALUES;
    w = cfg_width;

    // packing disabled or width too large
    if (count == 0 || w == 0 || w > msbbp_pkg::DEF_MAX_WIDTH) begin
      push_reject();
      return;
    end

    buf_bytes  = (count * w + 7) >> 3;
    start      = pos_bits;
    first_byte = start >> 3;
    // start byte past the end of the buffer
    if (first_byte >= buf_bytes) begin
      push_reject();
      return;
    end
    off = start & 7;

    // drop bits above the width, then line the value up under the held byte
    masked = v & 32'((64'd1 << w) - 64'd1);
    window = {held_byte, 32'd0} | ({8'd0, masked} << (msbbp_pkg::WIN_W - off - w));
    nb     = (off + w + 7) >> 3;

    // bytes past the buffer end are not written
    for (k = 0; k < nb && first_byte + k < buf_bytes; k++) begin
      bw.accepted  = 1'b1;
      bw.byte_addr = msbbp_pkg::ADDR_W'(first_byte + k);
      bw.byte_data = msbbp_pkg::BYTE_W'(window >> (32 - 8 * k));
      bw.last      = 1'b0;
      writes_due.push_back(bw);
    end
    writes_due[writes_due.size() - 1].last = 1'b1;

    // position moves on by the full width even on an overrun
    newpos   = start + w;
    pos_bits = msbbp_pkg::POS_W'(newpos);
    held_byte = ((newpos & 7) != 0) ? msbbp_pkg::BYTE_W'(window >> (32 - 8 * (nb - 1))) : '0;
  endfunction

  // ---------------------------------------------------------------------------
  // checker: each result beat against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_beats
    byte_write_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (writes_due.size() == 0) begin
        $error("unexpected result beat: addr %0h data %0h",
               result_ch.byte_addr, result_ch.byte_data);
        errors++;
      end else begin
        want = writes_due.pop_front();
        if (result_ch.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, result_ch.accepted);
          errors++;
        end
        if (result_ch.byte_addr !== want.byte_addr) begin
          $error("byte_addr: expected %0h, got %0h", want.byte_addr, result_ch.byte_addr);
          errors++;
        end
        if (result_ch.byte_data !== want.byte_data) begin
          $error("byte_data: expected %0h, got %0h", want.byte_data, result_ch.byte_data);
          errors++;
        end
        if (result_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, result_ch.last);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: ready follows the current stall pattern, a long hold wins
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (hold_req) begin
      hold_cycles     <= HOLD_CYCLES - 1;
      result_ch.ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles     <= hold_cycles - 1;
      result_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:    result_ch.ready <= 1'b1;
        RX_RANDOM:  result_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: result_ch.ready <= ((rx_phase % 7) >= 3);
        default:    result_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one value and wait until it is taken; valid stays high afterwards, so the
  // caller either sends again, idles or drains in the same step
  task automatic send_value(input logic [msbbp_pkg::VALUE_W-1:0] v);
    item_ch.valid <= 1'b1;
    item_ch.value <= v;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    pack_value(v);
  endtask

  // bursts of random length with random gaps between them
  task automatic pace();
    if (!sender_gaps) return;
    if (burst_left != 0) begin
      burst_left--;
      return;
    end
    item_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 8)) @(posedge clk);
    burst_left = $urandom_range(0, 7);
  endtask

  // stop offering and wait until every predicted beat has arrived
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (writes_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // register write while the packer is idle; any write restarts the buffer
  task automatic write_reg(input logic [msbbp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [msbbp_pkg::CFG_W-1:0] data);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == msbbp_pkg::REG_VALUE_COUNT) cfg_count = data[msbbp_pkg::COUNT_W-1:0];
    else cfg_width = data[msbbp_pkg::WIDTH_W-1:0];
    pos_bits  = '0;
    held_byte = '0;
    @(posedge clk);
  endtask

  // both layout registers; junk above the width field must be ignored
  task automatic set_layout(input int unsigned count, input int unsigned width);
    write_reg(msbbp_pkg::REG_VALUE_COUNT, msbbp_pkg::CFG_W'(count));
    write_reg(msbbp_pkg::REG_VALUE_WIDTH,
              {msbbp_pkg::CFG_W'($urandom_range(0, 1023)) << msbbp_pkg::WIDTH_W} |
              msbbp_pkg::CFG_W'(width[msbbp_pkg::WIDTH_W-1:0]));
  endtask

  function automatic logic [msbbp_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // out of reset the count is zero, so every value bounces
  task automatic test_reset_defaults();
    send_value(32'hFFFF_FFFF);
    send_value(32'h0000_0000);
    drain();
  endtask

  // zero count, zero width and widths above the limit all reject
  task automatic test_disabled_layouts();
    set_layout(0, 8);
    send_value(32'h0000_00A5);
    set_layout(4, 0);
    send_value(32'h1234_5678);
    set_layout(4, msbbp_pkg::DEF_MAX_WIDTH + 1);
    send_value(32'hFFFF_FFFF);
    set_layout(4, 63);
    send_value(32'h8000_0001);
    drain();
  endtask

  // widest and narrowest values, each run until the buffer is full
  task automatic test_width_extremes();
    int unsigned i;
    set_layout(2, msbbp_pkg::DEF_MAX_WIDTH);
    send_value(32'hFFFF_FFFF);
    send_value(32'h0000_0000);
    send_value(32'h1234_5678);
    // one-bit values fill a single byte, the ninth finds it full
    set_layout(8, 1);
    for (i = 0; i < 9; i++) send_value(($urandom & ~32'h1) | (i & 1));
    drain();
  endtask

  // a value hanging off the buffer end, and 28-bit values that span four bytes each
  task automatic test_overrun();
    set_layout(3, 5);
    send_value(32'hFFFF_FFFF);
    send_value(32'h0000_0015);
    send_value(32'hFFFF_FFE0);
    send_value(32'h0000_001F);
    send_value(32'h0000_0011);
    set_layout(4, 28);
    send_value(32'hFFFF_FFFF);
    send_value(32'hA5A5_A5A5);
    drain();
  endtask

  // largest buffer the count register allows
  task automatic test_max_count();
    set_layout(65535, msbbp_pkg::DEF_MAX_WIDTH);
    send_value(32'hFFFF_FFFF);
    send_value(32'h5A5A_0F0F);
    drain();
  endtask

  // long receiver stall while values keep coming, so the input backs up
  task automatic test_output_backpressure();
    int unsigned i;
    set_layout(4096, 29);
    rx_mode     = RX_OPEN;
    sender_gaps = 1'b0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (i = 0; i < 16; i++) send_value(pick_value());
    drain();
  endtask

  // sender stops mid-buffer until everything is out, then carries on
  task automatic test_sender_pause();
    int unsigned i;
    set_layout(40, 13);
    rx_mode = RX_RANDOM;
    for (i = 0; i < 6; i++) send_value(pick_value());
    drain();
    for (i = 0; i < 6; i++) send_value(pick_value());
    drain();
  endtask

  // random layouts, mostly small buffers so they fill up and overrun often
  task automatic test_random_packing();
    int unsigned sent;
    int unsigned n;
    int unsigned i;
    int unsigned width;
    int unsigned count;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0)
        width = ($urandom_range(0, 1) == 0) ? 0
              : $urandom_range(msbbp_pkg::DEF_MAX_WIDTH + 1, 63);
      else
        width = $urandom_range(1, msbbp_pkg::DEF_MAX_WIDTH);
      count = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 12);
      set_layout(count, width);
      rx_mode     = rx_mode_t'($urandom_range(0, 3));
      sender_gaps = ($urandom_range(0, 3) != 0);
      burst_left  = 0;
      n = $urandom_range(6, 18);
      for (i = 0; i < n; i++) begin
        send_value(pick_value());
        if (i == n / 2 && $urandom_range(0, 3) == 0) drain();
        else pace();
      end
      sent += n;
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    item_ch.valid   = 1'b0;
    item_ch.value   = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_disabled_layouts();
    test_width_extremes();
    test_overrun();
    test_max_count();
    test_output_backpressure();
    test_sender_pause();
    test_random_packing();

    // everything predicted has arrived; give stray beats time to show up
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0 && writes_due.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
sv/msbbp_pkg.sv
sv/msbbp_if.sv
sv/msbbp_front.sv
sv/msbbp_queue.sv
sv/msbbp_back.sv
sv/msbbp_top.sv
tb/tb_msb_first_bit_packer_top.sv
